[hw/rtl/ptpsb_pkg.sv]
// package for the point to polar scan binner
// holds sizes, status and register codes, and the cordic arctangent table
// no dependencies
`default_nettype none

package ptpsb_pkg;

  // bins and cordic depth
  localparam int NUM_BINS     = 512;
  localparam int CORDIC_STEPS = 16;

  localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int LIM_W      = 16 + $clog2(NUM_BINS + 1);
  localparam int DVS_W      = 16 + BIN_W;
  localparam int DIV_CNT_W  = $clog2(BIN_W + 1);
  localparam int SQRT_STEPS = 16;
  localparam int SQ_CNT_W   = $clog2(SQRT_STEPS);
  localparam int ATAN_LEN   = 24;
  localparam int CD_CNT_W   = $clog2(ATAN_LEN);
  localparam int CD_W       = 27;

  typedef logic [BIN_W-1:0]        bin_idx_t;
  typedef logic [DVS_W-1:0]        dvs_t;
  typedef logic [LIM_W-1:0]        lim_t;
  typedef logic signed [CD_W-1:0]  cd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_CLOSE  = 3'd1,
    ST_HEIGHT = 3'd2,
    ST_ANGLE  = 3'd3,
    ST_READ   = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_H     = 3'd0,
    CFG_MAX_H     = 3'd1,
    CFG_RNG_FLOOR = 3'd2,
    CFG_RAMP_ST   = 3'd3,
    CFG_RAMP_SLP  = 3'd4,
    CFG_FIRST_ANG = 3'd5,
    CFG_BIN_WIDTH = 3'd6,
    CFG_NO_RET    = 3'd7
  } cfg_idx_t;

  // arctan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

`default_nettype wire

[hw/rtl/point_to_polar_scan_binner.sv]
// point to polar scan binner: range, bearing, height gate and nearest-range bins
// point transaction: square-root and cordic iterations, ramp product, gates, bin divider,
// then the bin memory update and strobe; rejected points strobe from the gate check,
// bin reads from the read state, or directly from idle when beyond the table; one transaction at a time
// after reset a clearing pass fills the bin memory, busy stays high;
// results are a single-cycle strobe, the receiver cannot stall
`default_nettype none

module point_to_polar_scan_binner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_x_mm,
  input  wire logic signed [15:0] in_y_mm,
  input  wire logic signed [15:0] in_z_mm,
  input  wire logic [8:0]         in_read_bin,
  // result strobe
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [8:0]              out_hit_bin,
  output logic [15:0]             out_point_range_mm,
  output logic [15:0]             out_bin_range_mm,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,  // post-reset fill of the bin memory
    S_IDLE  = 9'b000000010,
    S_SQY   = 9'b000000100,  // second square, launch sqrt and cordic
    S_ITER  = 9'b000001000,  // wait for sqrt and cordic
    S_HMUL  = 9'b000010000,  // ramp product for the height floor
    S_CHECK = 9'b000100000,  // range, height and bearing gates
    S_DIV   = 9'b001000000,  // bin index division, then memory read
    S_MWR   = 9'b010000000,  // keep the nearer range, emit
    S_RWR   = 9'b100000000   // bin read: emit and clear
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [15:0] min_h_r, max_h_r, first_ang_r;
  logic [15:0]        rng_floor_r, ramp_st_r, ramp_slp_r, bin_width_r, no_ret_r;

  // latched transaction payload
  logic signed [15:0]  x_r, y_r, z_r;
  logic [8:0]          rb_r;
  ptpsb_pkg::bin_idx_t bin_r;
  logic [31:0]         acc_r, acc_nxt;
  logic                acc_we;

  // clearing pass counter
  ptpsb_pkg::bin_idx_t clr_cnt_r;

  // bin memory
  logic [15:0]         bin_mem [ptpsb_pkg::NUM_BINS];
  logic [15:0]         rd_data_r;
  ptpsb_pkg::bin_idx_t rd_addr, wr_addr;
  logic [15:0]         wr_data;
  logic                wr_en;

  // shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  // iterative units
  logic                sq_start, sq_busy;
  logic [15:0]         range_mm;
  logic                cd_busy;
  logic signed [15:0]  bearing;
  logic                dv_start, dv_busy;
  ptpsb_pkg::bin_idx_t dv_q;

  // gate arithmetic
  logic [15:0]        ramp_d;
  logic signed [17:0] floor_h, z_ext, max_ext;
  logic signed [16:0] diff;
  ptpsb_pkg::lim_t    width_eff, bin_lim;
  logic               rb_ok;
  logic [15:0]        nearer;

  // result staging
  logic        emit;
  logic [2:0]  emit_status;
  logic [8:0]  emit_hit;
  logic [15:0] emit_prange, emit_brange;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [8:0]  out_hit_r;
  logic [15:0] out_prange_r, out_brange_r;

  ptpsb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  (acc_nxt),
    .busy  (sq_busy),
    .root  (range_mm)
  );

  ptpsb_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .x_in    (x_r),
    .y_in    (y_r),
    .busy    (cd_busy),
    .bearing (bearing)
  );

  ptpsb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (diff[15:0]),
    .divisor  (width_eff[15:0]),
    .busy     (dv_busy),
    .quotient (dv_q)
  );

  // configuration transactions are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_h_r     <= 16'sd0;
      max_h_r     <= 16'sd1000;
      rng_floor_r <= 16'd450;
      ramp_st_r   <= 16'd2500;
      ramp_slp_r  <= 16'd2621;
      first_ang_r <= -16'sd16384;
      bin_width_r <= 16'd91;
      no_ret_r    <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ptpsb_pkg::cfg_idx_t'(cfg_index))
        ptpsb_pkg::CFG_MIN_H:     min_h_r     <= $signed(cfg_data);
        ptpsb_pkg::CFG_MAX_H:     max_h_r     <= $signed(cfg_data);
        ptpsb_pkg::CFG_RNG_FLOOR: rng_floor_r <= cfg_data;
        ptpsb_pkg::CFG_RAMP_ST:   ramp_st_r   <= cfg_data;
        ptpsb_pkg::CFG_RAMP_SLP:  ramp_slp_r  <= cfg_data;
        ptpsb_pkg::CFG_FIRST_ANG: first_ang_r <= $signed(cfg_data);
        ptpsb_pkg::CFG_BIN_WIDTH: bin_width_r <= cfg_data;
        ptpsb_pkg::CFG_NO_RET:    no_ret_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // gate arithmetic
  always_comb begin
    ramp_d    = (range_mm > ramp_st_r) ? 16'(range_mm - ramp_st_r) : 16'd0;
    // acc_r holds the ramp product while in the check state
    floor_h   = 18'(min_h_r) + $signed({2'b00, acc_r[31:16]});
    z_ext     = 18'(z_r);
    max_ext   = 18'(max_h_r);
    diff      = 17'(bearing) - 17'(first_ang_r);
    // zero bin width behaves as width one
    width_eff = (bin_width_r == 16'd0) ? ptpsb_pkg::lim_t'(1)
                                       : ptpsb_pkg::lim_t'(bin_width_r);
    bin_lim   = width_eff * ptpsb_pkg::lim_t'(ptpsb_pkg::NUM_BINS);
    rb_ok     = (32'(in_read_bin) < ptpsb_pkg::NUM_BINS);
    nearer    = (range_mm < rd_data_r) ? range_mm : rd_data_r;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 17'(in_x_mm);
    mul_b = 17'(in_x_mm);
    case (state_r)
      S_SQY: begin
        mul_a = 17'(y_r);
        mul_b = 17'(y_r);
      end
      S_HMUL: begin
        mul_a = $signed({1'b0, ramp_d});
        mul_b = $signed({1'b0, ramp_slp_r});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = 32'(mul_p);
    acc_we      = 1'b0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    rd_addr     = dv_q;
    wr_en       = 1'b0;
    wr_addr     = clr_cnt_r;
    wr_data     = 16'hFFFF;
    emit        = 1'b0;
    emit_status = ptpsb_pkg::ST_ACCEPT;
    emit_hit    = 9'd0;
    emit_prange = range_mm;
    emit_brange = 16'd0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_r == ptpsb_pkg::bin_idx_t'(ptpsb_pkg::NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = ptpsb_pkg::bin_idx_t'(in_read_bin);
        if (start) begin
          if (!in_mode) begin
            acc_we    = 1'b1;
            state_nxt = S_SQY;
          end else if (rb_ok) begin
            state_nxt = S_RWR;
          end else begin
            // bin beyond the table: report the no-return value, touch nothing
            emit        = 1'b1;
            emit_status = ptpsb_pkg::ST_READ;
            emit_hit    = in_read_bin;
            emit_prange = 16'd0;
            emit_brange = no_ret_r;
          end
        end
      end
      S_SQY: begin
        acc_nxt   = acc_r + 32'(mul_p);
        sq_start  = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        if (!sq_busy && !cd_busy) begin
          state_nxt = S_HMUL;
        end
      end
      S_HMUL: begin
        acc_we    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (range_mm < rng_floor_r) begin
          emit        = 1'b1;
          emit_status = ptpsb_pkg::ST_CLOSE;
          state_nxt   = S_IDLE;
        end else if (z_ext > max_ext || z_ext < floor_h) begin
          emit        = 1'b1;
          emit_status = ptpsb_pkg::ST_HEIGHT;
          state_nxt   = S_IDLE;
        end else if (diff[16] || ptpsb_pkg::lim_t'(diff[15:0]) >= bin_lim) begin
          // below the first bin, or past the last one
          emit        = 1'b1;
          emit_status = ptpsb_pkg::ST_ANGLE;
          state_nxt   = S_IDLE;
        end else begin
          dv_start  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!dv_busy) begin
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        wr_en       = 1'b1;
        wr_addr     = bin_r;
        wr_data     = nearer;
        emit        = 1'b1;
        emit_status = ptpsb_pkg::ST_ACCEPT;
        emit_hit    = 9'(bin_r);
        emit_brange = nearer;
        state_nxt   = S_IDLE;
      end
      S_RWR: begin
        wr_en       = 1'b1;
        wr_addr     = ptpsb_pkg::bin_idx_t'(rb_r);
        wr_data     = no_ret_r;
        emit        = 1'b1;
        emit_status = ptpsb_pkg::ST_READ;
        emit_hit    = rb_r;
        emit_prange = 16'd0;
        emit_brange = rd_data_r;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      x_r  <= in_x_mm;
      y_r  <= in_y_mm;
      z_r  <= in_z_mm;
      rb_r <= in_read_bin;
    end
    if (acc_we) begin
      acc_r <= acc_nxt;
    end
    if (state_r == S_DIV) begin
      bin_r <= dv_q;
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_hit_r    <= emit_hit;
      out_prange_r <= emit_prange;
      out_brange_r <= emit_brange;
    end
  end

  // bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= bin_mem[rd_addr];
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_hit_bin        = out_hit_r;
  assign out_point_range_mm = out_prange_r;
  assign out_bin_range_mm   = out_brange_r;

endmodule

`default_nettype wire

[hw/rtl/ptpsb_isqrt.sv]
// iterative integer square root, two radicand bits per cycle
// depends on ptpsb_pkg
`default_nettype none

module ptpsb_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] n_in,
  output logic             busy,
  output logic [15:0]      root
);

  logic                               busy_r;
  logic [ptpsb_pkg::SQ_CNT_W-1:0]     cnt_r;
  logic [31:0]                        n_r;
  logic [16:0]                        rem_r;
  logic [15:0]                        root_r;

  logic [18:0] rem2;
  logic [18:0] test;
  logic        fits;

  always_comb begin
    rem2 = {rem_r, n_r[31:30]};
    test = {1'b0, root_r, 2'b01};
    fits = (rem2 >= test);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == ptpsb_pkg::SQ_CNT_W'(ptpsb_pkg::SQRT_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n_in;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[29:0], 2'b00};
      if (fits) begin
        rem_r  <= 17'(rem2 - test);
        root_r <= {root_r[14:0], 1'b1};
      end else begin
        rem_r  <= rem2[16:0];
        root_r <= {root_r[14:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

[hw/rtl/ptpsb_cordic.sv]
// iterative cordic vectoring unit, one micro-rotation per cycle
// depends on ptpsb_pkg for the arctangent table and widths
`default_nettype none

module ptpsb_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  output logic                    busy,
  output logic signed [15:0]      bearing
);

  logic                             busy_r;
  logic [ptpsb_pkg::CD_CNT_W-1:0]   step_r;
  ptpsb_pkg::cd_t                   x_r;
  ptpsb_pkg::cd_t                   y_r;
  logic [31:0]                      acc_r;
  logic                             zero_r;

  ptpsb_pkg::cd_t xw;
  ptpsb_pkg::cd_t yw;
  ptpsb_pkg::cd_t xs;
  ptpsb_pkg::cd_t ys;
  logic [31:0]    ang;
  logic [31:0]    rnd;

  always_comb begin
    xw  = ptpsb_pkg::cd_t'(x_in) <<< 8;
    yw  = ptpsb_pkg::cd_t'(y_in) <<< 8;
    xs  = x_r >>> step_r;
    ys  = y_r >>> step_r;
    ang = ptpsb_pkg::ATAN_TAB[step_r];
    rnd = acc_r + 32'h0000_8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == ptpsb_pkg::CD_CNT_W'(ptpsb_pkg::CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == 16'sd0) && (y_in == 16'sd0);
      // quarter-turn pre-rotation into the right half plane
      if (x_in[15] && !y_in[15]) begin
        x_r   <= yw;
        y_r   <= -xw;
        acc_r <= 32'h4000_0000;
      end else if (x_in[15]) begin
        x_r   <= -yw;
        y_r   <= xw;
        acc_r <= 32'hC000_0000;
      end else begin
        x_r   <= xw;
        y_r   <= yw;
        acc_r <= '0;
      end
    end else if (busy_r) begin
      if (!y_r[ptpsb_pkg::CD_W-1]) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        acc_r <= acc_r + ang;
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        acc_r <= acc_r - ang;
      end
    end
  end

  assign busy    = busy_r;
  assign bearing = zero_r ? 16'sd0 : $signed(rnd[31:16]);

endmodule

`default_nettype wire

[hw/rtl/ptpsb_div.sv]
// restoring divider producing a bin index, one quotient bit per cycle
// dividend is known to be below divisor times the bin count; depends on ptpsb_pkg
`default_nettype none

module ptpsb_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output ptpsb_pkg::bin_idx_t quotient
);

  logic                              busy_r;
  logic [ptpsb_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [15:0]                       rem_r;
  ptpsb_pkg::dvs_t                   dvs_r;
  ptpsb_pkg::bin_idx_t               q_r;

  logic fits;

  always_comb begin
    fits = (ptpsb_pkg::dvs_t'(rem_r) >= dvs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == ptpsb_pkg::DIV_CNT_W'(ptpsb_pkg::BIN_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= ptpsb_pkg::dvs_t'(divisor) << (ptpsb_pkg::BIN_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      dvs_r <= dvs_r >> 1;
      if (fits) begin
        rem_r <= 16'(ptpsb_pkg::dvs_t'(rem_r) - dvs_r);
        q_r   <= ptpsb_pkg::bin_idx_t'({q_r, 1'b1});
      end else begin
        q_r   <= ptpsb_pkg::bin_idx_t'({q_r, 1'b0});
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[tb/tb_point_to_polar_scan_binner.sv]
// self-checking bench for point_to_polar_scan_binner: random and directed point and bin-read
// commands, a bit-exact scan predictor and a strobe checker; needs ptpsb_pkg and the block only
`default_nettype none

module tb_point_to_polar_scan_binner;
  import ptpsb_pkg::*;

  // rough accept-to-strobe time of a point transaction, from the iteration and divider step counts
  localparam int PIPE_LAT = 6 + ((CORDIC_STEPS > 16) ? CORDIC_STEPS : 16) + BIN_W;

  // arctan(2^-i) as a fraction of a full turn, 2^32 = 2 pi
  localparam logic [0:23][31:0] ARCTAN_STEP = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic               mode;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic [8:0]         read_bin;
  } scan_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  hit_bin;
    logic [15:0] point_range;
    logic [15:0] bin_range;
  } scan_result_t;

  // one value per register, indexed by cfg_idx_t
  typedef logic [7:0][15:0] cfg_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic               in_mode = 1'b0;
  logic signed [15:0] in_x_mm = '0;
  logic signed [15:0] in_y_mm = '0;
  logic signed [15:0] in_z_mm = '0;
  logic [8:0]         in_read_bin = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [8:0]         out_hit_bin;
  logic [15:0]        out_point_range_mm;
  logic [15:0]        out_bin_range_mm;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_MIN_H;
  logic [15:0]        cfg_data = '0;

  point_to_polar_scan_binner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_x_mm            (in_x_mm),
    .in_y_mm            (in_y_mm),
    .in_z_mm            (in_z_mm),
    .in_read_bin        (in_read_bin),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_hit_bin        (out_hit_bin),
    .out_point_range_mm (out_point_range_mm),
    .out_bin_range_mm   (out_bin_range_mm),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // scan predictor: shadow registers and bin memory, cordic angle in 32 bits, the rest in 64 bits
  // ---------------------------------------------------------------------------
  longint m_min_h, m_max_h, m_floor, m_ramp_start, m_ramp_slope;
  longint m_first, m_width, m_no_ret;
  logic [15:0] bin_store [NUM_BINS];

  scan_cmd_t    pending_cmds [$];     // commands not yet handed to the block
  scan_result_t pending_results [$];  // predictions waiting for their strobe
  scan_cmd_t    in_flight;            // command currently on the input ports
  int           sender_idle_pct = 0;
  int           mismatches = 0;

  function automatic void apply_reg(cfg_idx_t idx, logic [15:0] v);
    case (idx)
      CFG_MIN_H:     m_min_h = $signed(v);
      CFG_MAX_H:     m_max_h = $signed(v);
      CFG_RNG_FLOOR: m_floor = v;
      CFG_RAMP_ST:   m_ramp_start = v;
      CFG_RAMP_SLP:  m_ramp_slope = v;
      CFG_FIRST_ANG: m_first = $signed(v);
      CFG_BIN_WIDTH: m_width = v;
      CFG_NO_RET:    m_no_ret = v;
      default: ;
    endcase
  endfunction

  // floor of the euclidean norm, bit by bit from the top
  function automatic longint planar_range(longint x, longint y);
    longint n, root, trial;
    n = x * x + y * y;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // lower height limit, rising with range past the ramp start
  function automatic longint height_floor(longint rng);
    longint f;
    f = m_min_h;
    if (rng > m_ramp_start) f = f + (((rng - m_ramp_start) * m_ramp_slope) >>> 16);
    return f;
  endfunction

  // cordic vectoring on coordinates scaled by 256, 32-bit wrapping angle
  function automatic longint scan_bearing(longint xi, longint yi);
    longint x, y, t, xs, ys;
    logic [31:0] acc, rounded;
    logic signed [15:0] top;
    if (xi == 0 && yi == 0) return 0;
    x = xi * 256;
    y = yi * 256;
    acc = '0;
    // left half plane: quarter turn first so the iterations converge
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 32'h4000_0000;
      end else begin
        t = x; x = -y; y = t; acc = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc = acc + ARCTAN_STEP[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ARCTAN_STEP[i];
      end
    end
    rounded = acc + 32'h0000_8000;
    top = rounded[31:16];
    return top;
  endfunction

  // expected result of one command; updates the shadow bins
  function automatic scan_result_t bin_point(scan_cmd_t c);
    scan_result_t r;
    longint rng, diff, w, slot;
    r = '0;
    r.status = ST_ACCEPT;
    if (c.mode) begin
      r.status = ST_READ;
      r.hit_bin = c.read_bin;
      r.bin_range = m_no_ret[15:0];
      if (c.read_bin < NUM_BINS) begin
        r.bin_range = bin_store[c.read_bin];
        bin_store[c.read_bin] = m_no_ret[15:0];
      end
      return r;
    end
    rng = planar_range(c.x_mm, c.y_mm);
    r.point_range = rng[15:0];
    if (rng < m_floor) begin
      r.status = ST_CLOSE;
      return r;
    end
    if (c.z_mm > m_max_h || c.z_mm < height_floor(rng)) begin
      r.status = ST_HEIGHT;
      return r;
    end
    diff = scan_bearing(c.x_mm, c.y_mm) - m_first;
    w = (m_width == 0) ? 1 : m_width;  // zero width counts as one
    if (diff < 0) begin
      r.status = ST_ANGLE;             // no wrap around pi
      return r;
    end
    slot = diff / w;
    if (slot >= NUM_BINS) begin
      r.status = ST_ANGLE;
      return r;
    end
    if (rng < bin_store[slot]) bin_store[slot] = rng[15:0];
    r.hit_bin = slot[8:0];
    r.bin_range = bin_store[slot];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] to_mm(real v);
    longint q;
    q = (v >= 0.0) ? $rtoi(v + 0.5) : -$rtoi(-v + 0.5);
    return clamp16(q);
  endfunction

  function automatic scan_cmd_t mk_point(int x, int y, int z);
    scan_cmd_t c;
    c = '0;
    c.x_mm = x[15:0];
    c.y_mm = y[15:0];
    c.z_mm = z[15:0];
    c.read_bin = $urandom;
    return c;
  endfunction

  function automatic scan_cmd_t mk_read(int bin);
    scan_cmd_t c;
    c.mode = 1'b1;
    c.x_mm = $urandom;
    c.y_mm = $urandom;
    c.z_mm = $urandom;
    c.read_bin = bin[8:0];
    return c;
  endfunction

  function automatic cfg_set_t make_cfg(int min_h, int max_h, int rng_floor, int ramp_st,
                                        int slope, int first_ang, int width, int no_ret);
    cfg_set_t cs;
    cs[CFG_MIN_H]     = min_h[15:0];
    cs[CFG_MAX_H]     = max_h[15:0];
    cs[CFG_RNG_FLOOR] = rng_floor[15:0];
    cs[CFG_RAMP_ST]   = ramp_st[15:0];
    cs[CFG_RAMP_SLP]  = slope[15:0];
    cs[CFG_FIRST_ANG] = first_ang[15:0];
    cs[CFG_BIN_WIDTH] = width[15:0];
    cs[CFG_NO_RET]    = no_ret[15:0];
    return cs;
  endfunction

  function automatic cfg_set_t rand_cfg();
    int lo_h;
    lo_h = int'($urandom_range(2800)) - 2000;
    return make_cfg(lo_h, lo_h + int'($urandom_range(4000)), $urandom_range(2000),
                    $urandom_range(46341), $urandom_range(8000), $urandom,
                    $urandom_range(300, 1), $urandom);
  endfunction

  // well-formed point: bearing aimed into a live bin, range near or past the floor,
  // height mostly inside the band and often right on its edges
  function automatic scan_cmd_t aimed_point();
    scan_cmd_t c;
    longint w, top_bin, pick, ang, lo_r, hi_r, r, rng, lo_z, hi_z, z;
    real th;
    w = (m_width == 0) ? 1 : m_width;
    top_bin = (32767 - m_first) / w;
    if (top_bin > NUM_BINS - 1) top_bin = NUM_BINS - 1;
    pick = $urandom_range(top_bin);
    ang = m_first + pick * w;
    pick = $urandom_range(w - 1);
    ang = ang + pick;
    if (ang > 32767) ang = 32767;
    lo_r = m_floor;
    if ($urandom_range(4) == 0) lo_r = m_floor - 100;
    if (lo_r < 0) lo_r = 0;
    if (lo_r > 32767) lo_r = 32767;
    hi_r = $urandom_range(1) ? lo_r + 3000 : 32767;
    if (hi_r > 32767) hi_r = 32767;
    pick = $urandom_range(hi_r - lo_r);
    r = lo_r + pick;
    th = ang * 3.141592653589793 / 32768.0;
    c = '0;
    c.read_bin = $urandom;
    c.x_mm = to_mm(r * $cos(th));
    c.y_mm = to_mm(r * $sin(th));
    rng = planar_range(c.x_mm, c.y_mm);
    lo_z = height_floor(rng);
    if (lo_z < -32768) lo_z = -32768;
    hi_z = m_max_h;
    if (lo_z > hi_z) begin
      c.z_mm = $urandom;
    end else begin
      case ($urandom_range(7))
        0: z = lo_z;
        1: z = hi_z;
        2: z = lo_z - 1;
        3: z = hi_z + 1;
        default: begin
          pick = $urandom_range(hi_z - lo_z);
          z = lo_z + pick;
        end
      endcase
      c.z_mm = clamp16(z);
    end
    return c;
  endfunction

  // random mix: mostly aimed points, some bin reads, some raw noise
  function automatic scan_cmd_t next_cmd();
    scan_cmd_t c;
    case ($urandom_range(19))
      0, 1, 2: c = mk_read($urandom);
      3, 4, 5: c = mk_point($urandom, $urandom, $urandom);
      default: c = aimed_point();
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one command at a time, random gaps after each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    logic taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      // predict at the accepting edge so bins change in block order
      if (taken) pending_results.push_back(bin_point(in_flight));
      if (!start || taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_flight = pending_cmds.pop_front();
          start <= 1'b1;
          in_mode <= in_flight.mode;
          in_x_mm <= in_flight.x_mm;
          in_y_mm <= in_flight.y_mm;
          in_z_mm <= in_flight.z_mm;
          in_read_bin <= in_flight.read_bin;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe against the oldest prediction, field by field
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : mon
    scan_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result strobe with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_hit_bin !== want.hit_bin)
          flag_mismatch($sformatf("hit_bin %0d, want %0d", out_hit_bin, want.hit_bin));
        if (out_point_range_mm !== want.point_range)
          flag_mismatch($sformatf("point_range %0d, want %0d",
                                  out_point_range_mm, want.point_range));
        if (out_bin_range_mm !== want.bin_range)
          flag_mismatch($sformatf("bin_range %0d, want %0d",
                                  out_bin_range_mm, want.bin_range));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // wait at falling edges until every command is accepted and every result seen
  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || start || pending_results.size() != 0)
      @(negedge clk);
  endtask

  // all eight registers, back to back, each on its own handshake
  task automatic write_regs(cfg_set_t vals);
    @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // settle, reprogram, then queue a batch; the drain is also the sender's full pause
  task automatic run_phase(cfg_set_t cs, int n_items, int idle);
    drain();
    repeat (PIPE_LAT) @(posedge clk);
    write_regs(cs);
    @(negedge clk);
    sender_idle_pct = idle;
    repeat (n_items) pending_cmds.push_back(next_cmd());
  endtask

  initial begin : seq
    cfg_set_t reset_cfg, narrow;
    reset_cfg = make_cfg(0, 1000, 450, 2500, 2621, -16384, 91, 65535);
    for (int i = 0; i < 8; i++) apply_reg(cfg_idx_t'(i), reset_cfg[i]);
    for (int i = 0; i < NUM_BINS; i++) bin_store[i] = 16'hFFFF;
    sender_idle_pct = 23;

    // directed, reset settings
    pending_cmds.push_back(mk_read(0));
    pending_cmds.push_back(mk_read(511));
    pending_cmds.push_back(mk_point(1000, 0, 100));     // straight ahead, hits a bin
    pending_cmds.push_back(mk_point(2000, 0, 100));     // farther, bin keeps its range
    pending_cmds.push_back(mk_point(500, 0, 100));      // nearer, bin lowered
    pending_cmds.push_back(mk_read(180));               // bin holding bearing zero
    pending_cmds.push_back(mk_read(180));               // now back to no return
    pending_cmds.push_back(mk_point(100, 100, 0));      // too close
    pending_cmds.push_back(mk_point(1000, 0, 2000));    // above the band
    pending_cmds.push_back(mk_point(1000, 0, -1));      // below the band
    pending_cmds.push_back(mk_point(20000, 0, 600));    // under the ramped floor
    pending_cmds.push_back(mk_point(20000, 0, 800));    // over the ramped floor
    pending_cmds.push_back(mk_point(-1000, -1000, 100)); // bearing before first bin
    pending_cmds.push_back(mk_point(-1000, 1, 100));    // bin index past the end
    pending_cmds.push_back(mk_point(-32768, -32768, -32768));
    pending_cmds.push_back(mk_point(32767, 32767, 32767));
    pending_cmds.push_back(mk_point(32767, -32768, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, extreme settings: zero floor, zero bin width, zero no-return value
    run_phase(make_cfg(-32768, 32767, 0, 0, 65535, -32768, 0, 0), 0, 23);
    pending_cmds.push_back(mk_point(0, 0, 0));           // origin, bearing zero
    pending_cmds.push_back(mk_point(-1000, 0, 32767));   // bearing at pi, first bin
    pending_cmds.push_back(mk_point(-1000, 0, -32768));  // steep ramp rejects it
    pending_cmds.push_back(mk_read(0));
    pending_cmds.push_back(mk_read(0));                  // cleared to the new value
    pending_cmds.push_back(mk_point(-1000, 0, 32767));   // zero stored, not lowered
    pending_cmds.push_back(mk_read(5));                  // old no-return value kept
    pending_cmds.push_back(mk_read(NUM_BINS - 1));

    // random phases: sender gaps 23%, then 84%, then none
    run_phase(reset_cfg, 310, 23);
    run_phase(make_cfg(-500, 2000, 0, 1000, 65535, -32768, 128, 12345), 310, 23);
    run_phase(rand_cfg(), 310, 84);
    narrow = rand_cfg();
    narrow[CFG_BIN_WIDTH] = 16'd1;
    narrow[CFG_RNG_FLOOR] = 16'd0;
    narrow[CFG_NO_RET] = 16'd0;
    run_phase(narrow, 310, 84);
    run_phase(rand_cfg(), 310, 0);
    run_phase(make_cfg(-32768, 32767, 0, 0, 0, -32768, 65535, 0), 260, 0);
    run_phase(make_cfg(32767, -32768, 46341, 46341, 0, 32767, 1, 65535), 30, 0);

    drain();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : guard
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
